@@ rtl/sphcs_pkg.sv @@
package sphcs_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned DIV_W = 64;
  localparam int unsigned DIVISOR_W = 32;

  localparam logic [1:0] REG_INV_H = 2'd0;
  localparam logic [1:0] REG_MASS = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  localparam logic [31:0] INV_H_RESET = 32'd1048576;
  localparam logic [31:0] MASS_RESET = 32'd1048576;

  localparam logic [44:0] Q_ONE = 45'd1048576;
  localparam logic [44:0] Q_TWO = 45'd2097152;
  localparam logic [44:0] Q_LIMIT = 45'd2202009;
  // ceil(2^34 / 3), exact division by three for operands below 2^33
  localparam logic [32:0] RECIP3 = 33'h1_5555_5556;

  localparam logic signed [SUM_W:0] SUM_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W:0] SUM_MIN = -49'sh0_8000_0000_0000;

  typedef struct packed {
    logic [32:0] sep;
    logic signed [31:0] value;
    logic [31:0] density;
    logic last;
  } entry_t;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QMUL,
    ST_SQ,
    ST_CUBE,
    ST_WMUL,
    ST_WDIV,
    ST_TMUL,
    ST_TDIV,
    ST_ACC,
    ST_FIN,
    ST_OMUL,
    ST_OUT
  } state_t;

endpackage

@@ rtl/sph_cubic_spline_density_sum.sv @@
// Sums the cubic spline kernel over the neighbours of one target particle, in
// Q12.20 fixed point. Each request carries one neighbour; the request with last
// set also returns mass times the sum (saturated to 48 bits), the number of
// neighbours within range (in interpolation mode, of nonzero density), and
// flags, and clears the running state. A two-entry queue takes requests while
// the back end works. The back end handles one request at a time, and a last
// request waits while the output is stalled. The kernel scale is a reciprocal
// multiply; the value over density term in interpolation mode uses a 64-step
// radix-2 divider.
module sph_cubic_spline_density_sum import sphcs_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = 4096
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [31:0] target_coord,
  input  logic signed [31:0] neighbor_coord,
  input  logic signed [31:0] neighbor_value,
  input  logic [31:0] neighbor_density,
  input  logic last,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [47:0] sum_result,
  output logic [12:0] contributing_count,
  output logic empty_sum,
  output logic zero_density_seen,
  output logic saturated
);

  logic [31:0] inv_smoothing_length;
  logic [31:0] particle_mass;
  logic sum_mode;
  logic pop;
  logic not_empty;
  entry_t head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_smoothing_length <= INV_H_RESET;
      particle_mass <= MASS_RESET;
      sum_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_H: inv_smoothing_length <= cfg_data;
        REG_MASS: particle_mass <= cfg_data;
        REG_MODE: sum_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sphcs_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .target_coord(target_coord),
    .neighbor_coord(neighbor_coord),
    .neighbor_value(neighbor_value),
    .neighbor_density(neighbor_density),
    .last(last),
    .pop(pop),
    .not_empty(not_empty),
    .head(head)
  );

  sphcs_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  sphcs_back #(
    .MAX_NEIGHBORS(MAX_NEIGHBORS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .inv_h(inv_smoothing_length),
    .mass(particle_mass),
    .mode(sum_mode),
    .not_empty(not_empty),
    .head(head),
    .pop(pop),
    .div_req(div_req),
    .div_rsp(div_rsp),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sum_result(sum_result),
    .contributing_count(contributing_count),
    .empty_sum(empty_sum),
    .zero_density_seen(zero_density_seen),
    .saturated(saturated)
  );

endmodule

@@ rtl/sphcs_front.sv @@
module sphcs_front import sphcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [31:0] target_coord,
  input  logic signed [31:0] neighbor_coord,
  input  logic signed [31:0] neighbor_value,
  input  logic [31:0] neighbor_density,
  input  logic last,
  input  logic pop,
  output logic not_empty,
  output entry_t head
);

  entry_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic push;
  logic signed [33:0] dx;
  entry_t incoming;

  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign not_empty = (fill != 2'd0);
  assign head = slots[rd_ptr];

  // distance is exact in 33 bits
  assign dx = 34'(target_coord) - 34'(neighbor_coord);

  always_comb begin
    incoming.sep = dx[33] ? 33'(-dx) : dx[32:0];
    incoming.value = neighbor_value;
    incoming.density = neighbor_density;
    incoming.last = last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/sphcs_div.sv @@
module sphcs_div import sphcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic busy;
  logic finished;
  logic [6:0] steps;
  logic [DIV_W-1:0] dq;
  logic [DIVISOR_W:0] rem;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIVISOR_W:0] rem_sh;
  logic fits;

  assign rem_sh = {rem[DIVISOR_W-1:0], dq[DIV_W-1]};
  assign fits = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      steps <= '0;
      finished <= 1'b0;
    end else begin
      finished <= busy && !req.start && (steps == 7'd1);
      if (req.start) begin
        busy <= 1'b1;
        steps <= 7'(DIV_W);
      end else if (busy) begin
        steps <= steps - 7'd1;
        if (steps == 7'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq <= req.dividend;
      rem <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
      dq <= {dq[DIV_W-2:0], fits};
    end
  end

  assign rsp = '{done: finished, quotient: dq};

endmodule

@@ rtl/sphcs_back.sv @@
module sphcs_back import sphcs_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = 4096
) (
  input  logic clk,
  input  logic rst,
  input  logic [31:0] inv_h,
  input  logic [31:0] mass,
  input  logic mode,
  input  logic not_empty,
  input  entry_t head,
  output logic pop,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [47:0] sum_result,
  output logic [12:0] contributing_count,
  output logic empty_sum,
  output logic zero_density_seen,
  output logic saturated
);

  localparam logic [COUNT_W-1:0] CAP =
    (MAX_NEIGHBORS > 8191) ? COUNT_W'(8191) : COUNT_W'(MAX_NEIGHBORS);

  state_t state, state_next;
  entry_t item;
  logic [44:0] q;
  logic [20:0] base;
  logic [20:0] sq;
  logic [20:0] p;
  logic [32:0] wnum;
  logic [31:0] w;
  logic signed [SUM_W:0] term;
  logic signed [SUM_W-1:0] kernel_sum;
  logic [COUNT_W-1:0] count;
  logic [1:0] flags;
  logic [59:0] hi_prod;
  logic out_free;

  logic [64:0] q_full;
  logic [20:0] base_c;
  logic [41:0] sq_full;
  logic [41:0] cube_full;
  logic [20:0] cube;
  logic [23:0] poly;
  logic [52:0] ph;
  logic [65:0] w_full;
  logic [31:0] w_c;
  logic [31:0] val_mag;
  logic [47:0] t_clamp;
  logic signed [SUM_W:0] term_c;
  logic signed [SUM_W:0] acc;
  logic [47:0] sum_mag;
  logic [51:0] lo_prod;
  logic [60:0] prod;
  logic out_neg;
  logic out_clip;
  logic [47:0] prod_c;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    q_full = 65'(item.sep) * 65'(inv_h);
    base_c = (q <= Q_ONE) ? q[20:0] : 21'(Q_TWO - q);
    sq_full = 42'(base_c) * 42'(base_c);
    cube_full = 42'(sq) * 42'(base);
    cube = cube_full[40:20];
    poly = 24'd1048576 - ((24'(sq) * 24'd3) >> 1) + ((24'(cube) * 24'd3) >> 2);
    ph = 53'(p) * 53'(inv_h);
    // kernel scale by two thirds through a reciprocal multiply
    w_full = 66'(wnum) * 66'(RECIP3);
    w_c = w_full[65:34];
    val_mag = item.value[31] ? 32'(-33'(item.value)) : item.value;
    t_clamp = (div_rsp.quotient > 64'h0000_8000_0000_0000) ? 48'h8000_0000_0000
                                                           : div_rsp.quotient[47:0];
    term_c = (term > SUM_MAX) ? SUM_MAX : term;
    acc = (SUM_W+1)'(kernel_sum) + term_c;
    sum_mag = kernel_sum[SUM_W-1] ? 48'(-49'(kernel_sum)) : kernel_sum;
    lo_prod = 52'(sum_mag[19:0]) * 52'(mass);
    prod = 61'(hi_prod) + 61'(lo_prod[51:20]);
    out_neg = kernel_sum[SUM_W-1];
    if (out_neg) begin
      out_clip = prod > 61'h0_8000_0000_0000;
      prod_c = out_clip ? 48'h8000_0000_0000 : prod[47:0];
    end else begin
      out_clip = prod > 61'h0_7FFF_FFFF_FFFF;
      prod_c = out_clip ? 48'h7FFF_FFFF_FFFF : prod[47:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (not_empty) state_next = ST_QMUL;
      ST_QMUL: state_next = ST_SQ;
      ST_SQ: state_next = (q > Q_TWO) ? ST_WMUL : ST_CUBE;
      ST_CUBE: state_next = ST_WMUL;
      ST_WMUL: state_next = ST_WDIV;
      ST_WDIV: begin
        priority if (q > Q_LIMIT) state_next = ST_FIN;
        else if (!mode) state_next = ST_ACC;
        else if (item.density == '0) state_next = ST_FIN;
        else state_next = ST_TMUL;
      end
      ST_TMUL: state_next = ST_TDIV;
      ST_TDIV: if (div_rsp.done) state_next = ST_ACC;
      ST_ACC: state_next = ST_FIN;
      ST_FIN: state_next = item.last ? ST_OMUL : ST_IDLE;
      ST_OMUL: state_next = ST_OUT;
      ST_OUT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    div_req.start = 1'b0;
    div_req.dividend = 64'(val_mag) * 64'(w);
    div_req.divisor = item.density;
    unique case (state)
      ST_IDLE: pop = not_empty;
      ST_TMUL: div_req.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: item <= head;
      ST_QMUL: q <= q_full[64:20];
      ST_SQ: begin
        base <= base_c;
        sq <= sq_full[40:20];
        if (q > Q_TWO) begin
          p <= '0;
        end
      end
      ST_CUBE: begin
        if (q <= Q_ONE) begin
          p <= poly[20:0];
        end else begin
          p <= {2'd0, cube[20:2]};
        end
      end
      ST_WMUL: wnum <= ph[51:19];
      ST_WDIV: begin
        w <= w_c;
        term <= (SUM_W+1)'(w_c);
      end
      ST_TDIV: term <= item.value[31] ? -(SUM_W+1)'(t_clamp) : (SUM_W+1)'(t_clamp);
      ST_OMUL: hi_prod <= 60'(sum_mag[47:20]) * 60'(mass);
      default: ;
    endcase
  end

  // accumulator state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_sum <= '0;
      count <= '0;
      flags <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_WDIV && q <= Q_LIMIT && mode && item.density == '0) begin
        flags[0] <= 1'b1;
      end
      if (state == ST_ACC) begin
        if (acc > SUM_MAX) begin
          kernel_sum <= SUM_MAX[SUM_W-1:0];
        end else if (acc < SUM_MIN) begin
          kernel_sum <= SUM_MIN[SUM_W-1:0];
        end else begin
          kernel_sum <= acc[SUM_W-1:0];
        end
        if (term > SUM_MAX || acc > SUM_MAX || acc < SUM_MIN) begin
          flags[1] <= 1'b1;
        end
        if (count < CAP) begin
          count <= count + COUNT_W'(1);
        end
      end
      if (state == ST_OUT && out_free) begin
        kernel_sum <= '0;
        count <= '0;
        flags <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      sum_result <= out_neg ? -prod_c : prod_c;
      contributing_count <= count;
      empty_sum <= out_neg || (kernel_sum == '0);
      zero_density_seen <= flags[0];
      saturated <= flags[1] || out_clip;
    end
  end

endmodule
